/* design/graph_connected_components_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the connected components block
// Shared property wrappers, clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef GRAPH_CONNECTED_COMPONENTS_MACROS_SVH
`define GRAPH_CONNECTED_COMPONENTS_MACROS_SVH

// Check outside of reset only
`define GCC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check at every edge, reset included
`define GCC_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

/* design/gcc_pkg.sv */
// ---------------------------------------------------------------------------
// gcc_pkg
// Types and constants shared by the connected components block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcc_pkg;

  localparam int unsigned NumVert  = 64;
  localparam int unsigned VertW    = $clog2(NumVert);
  localparam int unsigned CntW     = VertW + 1;
  localparam int unsigned EdgeW    = 12;
  localparam int unsigned ReqW     = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_COUNT  = 2'd2
  } req_type_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_SCAN,
    S_ROW,
    S_PUSH,
    S_POP,
    S_TOP
  } gcc_state_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [VertW-1:0] vertex_a;
    logic [VertW-1:0] vertex_b;
  } gcc_req_t;

  typedef struct packed {
    logic             status;
    logic [CntW-1:0]  component_count;
    logic [EdgeW-1:0] edge_count;
  } gcc_res_t;

  // Row memory port: one write and one read address per cycle
  typedef struct packed {
    logic               we;
    logic [VertW-1:0]   waddr;
    logic [NumVert-1:0] wdata;
    logic [VertW-1:0]   raddr;
  } gcc_row_req_t;

endpackage

/* design/graph_connected_components.sv */
// Insert/remove: the result is registered from the accepting cycle when ignored, from
// S_EDGE_A when the matrix is unchanged or a self-loop, and from S_EDGE_B with the
// symmetric row write-back. Count: S_SCAN walks the vertices, a root reads its row,
// and each other reached vertex is pushed, popped, read from the stack, then row-read.
// One item at a time. Results are one-cycle strobes; reset clears the matrix at once
// through row valid bits, so no clearing pass runs and start is taken right after reset.
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// graph_connected_components
// Bit adjacency matrix with edge count and depth-first component counting.
// ---------------------------------------------------------------------------
module graph_connected_components
  import gcc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            start,
  input  gcc_req_t        req_i,
  output logic            busy,
  output logic            done_o,
  output gcc_res_t        res_o
);

  gcc_state_e         state_q, state_d;
  logic [CntW-1:0]    vcount_q;
  logic [CntW-1:0]    n_eff;
  logic [NumVert-1:0] lim;

  logic [VertW-1:0]   a_q, a_d, b_q, b_d;
  logic               ins_q, ins_d;
  logic [NumVert-1:0] visited_q, visited_d;
  logic [NumVert-1:0] push_q, push_d;
  logic [CntW-1:0]    sp_q, sp_d;
  logic [CntW-1:0]    s_q, s_d;
  logic [CntW-1:0]    comps_q, comps_d;
  logic [CntW-1:0]    last_q, last_d;
  logic [EdgeW-1:0]   edges_q, edges_d;
  logic               done_q, done_d;
  gcc_res_t           res_q, res_d;

  gcc_row_req_t       row_req;
  logic [NumVert-1:0] row_rdata;
  logic [NumVert-1:0] row_new;
  logic               hit;
  logic               change;

  logic [VertW-1:0]   stack_mem [NumVert];
  logic [VertW-1:0]   stack_rdata_q;
  logic               stack_we;
  logic [VertW-1:0]   stack_waddr, stack_raddr;
  logic [VertW-1:0]   low_idx;

  logic               finish;
  logic               fin_status;
  logic               accept;

  gcc_adj_mem u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (row_req),
    .rdata_o (row_rdata)
  );

  assign n_eff  = (vcount_q > CntW'(NumVert)) ? CntW'(NumVert) : vcount_q;
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    for (int i = 0; i < NumVert; i++) begin
      lim[i] = (CntW'(i) < n_eff);
    end
  end

  // Lowest pending neighbor to push
  always_comb begin
    low_idx = '0;
    for (int i = NumVert - 1; i >= 0; i--) begin
      if (push_q[i]) begin
        low_idx = VertW'(i);
      end
    end
  end

  assign hit     = row_rdata[b_q];
  assign change  = ins_q ? !hit : hit;
  assign row_new = row_rdata & ~visited_q & lim;

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    ins_d        = ins_q;
    visited_d    = visited_q;
    push_d       = push_q;
    sp_d         = sp_q;
    s_d          = s_q;
    comps_d      = comps_q;
    last_d       = last_q;
    edges_d      = edges_q;
    finish       = 1'b0;
    fin_status   = 1'b0;
    row_req      = '0;
    stack_we     = 1'b0;
    stack_waddr  = sp_q[VertW-1:0];
    stack_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          a_d             = req_i.vertex_a;
          b_d             = req_i.vertex_b;
          ins_d           = (req_i.req_type == REQ_INSERT);
          row_req.raddr   = req_i.vertex_a;
          case (req_i.req_type)
            REQ_INSERT, REQ_REMOVE: begin
              if ({1'b0, req_i.vertex_a} >= n_eff || {1'b0, req_i.vertex_b} >= n_eff) begin
                finish     = 1'b1;
                fin_status = 1'b1;
              end else begin
                state_d = S_EDGE_A;
              end
            end
            REQ_COUNT: begin
              visited_d = '0;
              s_d       = '0;
              sp_d      = '0;
              comps_d   = '0;
              state_d   = S_SCAN;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_EDGE_A: begin
        row_req.raddr = b_q;
        if (change) begin
          row_req.we    = 1'b1;
          row_req.waddr = a_q;
          row_req.wdata = row_rdata;
          row_req.wdata[b_q] = ins_q;
          edges_d = ins_q ? edges_q + 1'b1 : edges_q - 1'b1;
        end
        if (change && (a_q != b_q)) begin
          state_d = S_EDGE_B;
        end else begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EDGE_B: begin
        // Mirror bit in the other endpoint's row
        row_req.we         = 1'b1;
        row_req.waddr      = b_q;
        row_req.wdata      = row_rdata;
        row_req.wdata[a_q] = ins_q;
        finish             = 1'b1;
        state_d            = S_IDLE;
      end
      S_SCAN: begin
        if (s_q >= n_eff) begin
          last_d  = comps_q;
          finish  = 1'b1;
          state_d = S_IDLE;
        end else if (visited_q[s_q[VertW-1:0]]) begin
          s_d = s_q + 1'b1;
        end else begin
          // New root: open a component and fetch its row
          visited_d[s_q[VertW-1:0]] = 1'b1;
          comps_d       = comps_q + 1'b1;
          row_req.raddr = s_q[VertW-1:0];
          s_d           = s_q + 1'b1;
          state_d       = S_ROW;
        end
      end
      S_ROW: begin
        visited_d = visited_q | row_new;
        push_d    = row_new;
        if (row_new != '0) begin
          state_d = S_PUSH;
        end else if (sp_q == '0) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_POP;
        end
      end
      S_PUSH: begin
        stack_we         = 1'b1;
        stack_waddr      = sp_q[VertW-1:0];
        sp_d             = sp_q + 1'b1;
        push_d[low_idx]  = 1'b0;
        if ((push_q & (push_q - 1'b1)) == '0) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        sp_d        = sp_q - 1'b1;
        stack_raddr = sp_d[VertW-1:0];
        state_d     = S_TOP;
      end
      S_TOP: begin
        row_req.raddr = stack_rdata_q;
        state_d       = S_ROW;
      end
      default: state_d = S_IDLE;
    endcase

    done_d                = finish;
    res_d                 = res_q;
    if (finish) begin
      res_d.status          = fin_status;
      res_d.component_count = last_d;
      res_d.edge_count      = edges_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= low_idx;
    end
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    ins_q  <= ins_d;
    push_q <= push_d;
    s_q    <= s_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vcount_q  <= CntW'(NumVert);
      visited_q <= '0;
      sp_q      <= '0;
      comps_q   <= '0;
      last_q    <= '0;
      edges_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      visited_q <= visited_d;
      sp_q      <= sp_d;
      comps_q   <= comps_d;
      last_q    <= last_d;
      edges_q   <= edges_d;
      done_q    <= done_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* design/gcc_adj_mem.sv */
// ---------------------------------------------------------------------------
// gcc_adj_mem
// Adjacency row memory with per-row valid bits; an unwritten row reads zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcc_adj_mem
  import gcc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gcc_row_req_t       req_i,
  output logic [NumVert-1:0] rdata_o
);

  logic [NumVert-1:0] mem [NumVert];
  logic [NumVert-1:0] rdata_q;
  logic [NumVert-1:0] row_valid_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_valid_q[req_i.waddr] <= 1'b1;
      end
      rd_valid_q <= row_valid_q[req_i.raddr];
    end
  end

  assign rdata_o = rd_valid_q ? rdata_q : '0;

endmodule

/* design/gcc_checker.sv */
// ---------------------------------------------------------------------------
// gcc_checker
// Port-level checks on the connected components block, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "graph_connected_components_macros.svh"

module gcc_checker
  import gcc_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_we_i,
  input logic [CntW-1:0] cfg_wdata_i,
  input logic            start,
  input gcc_req_t        req_i,
  input logic            busy,
  input logic            done_o,
  input gcc_res_t        res_o
);

  // An accepted beat either finishes at once or holds the block busy
  `GCC_ASSERT_RUN(a_accept_progress, start && !busy |=> done_o || busy, "accepted beat lost")

  // A result beat leaves the block free for the next item
  `GCC_ASSERT_RUN(a_done_idle, done_o |-> !busy, "result shown while busy")

  // Busy only rises on an accepted beat
  `GCC_ASSERT_RUN(a_busy_cause, $rose(busy) |-> $past(start), "busy without start")

  // Out-of-range requests are flagged on the beat after acceptance
  `GCC_ASSERT_RUN(a_flag_fast, done_o && res_o.status |-> $past(start && !busy), "late flag")

  // Reset idles the block
  `GCC_ASSERT_ALL(a_reset_idle, !rst_ni |-> !busy && !done_o, "active in reset")

endmodule

bind graph_connected_components gcc_checker u_gcc_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// testbench
// Drives edge inserts, edge removes and component counts into the graph block
// under several vertex counts, and checks every result beat against a fixed
// value or an in-bench adjacency matrix flooding each component to count it.
// ---------------------------------------------------------------------------
module testbench;
  import gcc_pkg::*;

  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned RandPerPhase = 113;
  localparam int unsigned NumPhases = 10;

  typedef struct {
    logic [CntW-1:0] vcnt;
    gcc_req_t        req;
    bit              typed;
    gcc_res_t        res;
  } plan_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;
  logic            start;
  gcc_req_t        req_i;
  logic            busy;
  logic            done_o;
  gcc_res_t        res_o;

  // Graph mirror
  logic [NumVert-1:0] adj_rows [NumVert];
  logic [EdgeW-1:0]   edges_now;
  logic [CntW-1:0]    comps_now;
  logic [CntW-1:0]    vcnt_now;

  gcc_res_t    results_due[$];
  plan_row_t   directed_plan[$];
  logic [VertW-1:0] recent_a [16];
  logic [VertW-1:0] recent_b [16];
  int unsigned recent_wr;
  bit          idle_en;
  int unsigned fails;
  int unsigned cycles;
  int unsigned n_items, n_counts, n_flagged, n_cfg;

  graph_connected_components uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  always #1 clk_i = ~clk_i;

  // Count components among vertices below n by flooding each unseen seed
  function automatic logic [CntW-1:0] tally_components(int unsigned n);
    logic [NumVert-1:0] in_use;
    logic [NumVert-1:0] seen;
    logic [NumVert-1:0] reach;
    logic [NumVert-1:0] grown;
    int unsigned groups;
    in_use = (n >= NumVert) ? '1 : ((64'd1 << n) - 64'd1);
    seen = '0;
    groups = 0;
    for (int s = 0; s < n; s++) begin
      if (!seen[s]) begin
        groups++;
        reach = 64'd1 << s;
        grown = '0;
        while (grown != reach) begin
          grown = reach;
          for (int t = 0; t < NumVert; t++) begin
            if (grown[t]) reach = reach | (adj_rows[t] & in_use);
          end
        end
        seen = seen | reach;
      end
    end
    return groups[CntW-1:0];
  endfunction

  // Apply one request to the mirror and return the result it must produce
  function automatic gcc_res_t graph_step(gcc_req_t r);
    int unsigned n;
    gcc_res_t    res;
    n = (vcnt_now > NumVert) ? NumVert : vcnt_now;
    res.status = 1'b0;
    case (r.req_type)
      REQ_INSERT, REQ_REMOVE: begin
        if (r.vertex_a >= n || r.vertex_b >= n) begin
          res.status = 1'b1;
        end else if (r.req_type == REQ_INSERT) begin
          if (!adj_rows[r.vertex_a][r.vertex_b]) begin
            adj_rows[r.vertex_a][r.vertex_b] = 1'b1;
            adj_rows[r.vertex_b][r.vertex_a] = 1'b1;
            edges_now = edges_now + 1'b1;
          end
        end else if (adj_rows[r.vertex_a][r.vertex_b]) begin
          adj_rows[r.vertex_a][r.vertex_b] = 1'b0;
          adj_rows[r.vertex_b][r.vertex_a] = 1'b0;
          edges_now = edges_now - 1'b1;
        end
      end
      REQ_COUNT: begin
        comps_now = tally_components(n);
      end
      default: ;
    endcase
    res.component_count = comps_now;
    res.edge_count = edges_now;
    return res;
  endfunction

  function automatic plan_row_t plan(int unsigned vcnt, logic [ReqW-1:0] op,
                                     int unsigned a, int unsigned b, int unsigned typed,
                                     int unsigned st, int unsigned cc, int unsigned ec);
    plan_row_t row;
    row.vcnt  = vcnt[CntW-1:0];
    row.req   = '{req_type: op, vertex_a: a[VertW-1:0], vertex_b: b[VertW-1:0]};
    row.typed = (typed != 0);
    row.res   = '{status: st[0], component_count: cc[CntW-1:0], edge_count: ec[EdgeW-1:0]};
    return row;
  endfunction

  // Hold start until the beat is taken, then log what it must return
  task automatic issue(gcc_req_t r, bit typed, gcc_res_t typed_res);
    gcc_res_t predicted;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = graph_step(r);
    results_due.push_back(typed ? typed_res : predicted);
    n_items++;
    if (r.req_type == REQ_COUNT) n_counts++;
    if (predicted.status) n_flagged++;
  endtask

  task automatic pause_sender();
    if (idle_en && $urandom_range(99) < 32) begin
      start <= 1'b0;
      if ($urandom_range(99) < 3) begin
        do @(posedge clk_i); while (results_due.size() != 0);
      end else begin
        do @(posedge clk_i); while ($urandom_range(99) < 32);
      end
    end
  endtask

  // Drain, then write the register while the block sits idle
  task automatic set_vertex_count(logic [CntW-1:0] v);
    start <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0 || busy);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    vcnt_now = v;
    n_cfg++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [VertW-1:0] pick_vertex(int unsigned n);
    if (n == 0 || $urandom_range(99) < 8) return VertW'($urandom_range(NumVert - 1));
    return VertW'($urandom_range(n - 1));
  endfunction

  function automatic gcc_req_t random_req();
    gcc_req_t    r;
    int unsigned n;
    int unsigned k;
    int unsigned slot;
    n = (vcnt_now > NumVert) ? NumVert : vcnt_now;
    k = $urandom_range(99);
    r.vertex_a = pick_vertex(n);
    r.vertex_b = pick_vertex(n);
    if (k < 45) begin
      r.req_type = REQ_INSERT;
      recent_a[recent_wr] = r.vertex_a;
      recent_b[recent_wr] = r.vertex_b;
      recent_wr = (recent_wr + 1) % 16;
    end else if (k < 72) begin
      r.req_type = REQ_REMOVE;
      // aim about half of the removes at edges that were likely stored
      if ($urandom_range(1)) begin
        slot = $urandom_range(15);
        if ($urandom_range(1)) begin
          r.vertex_a = recent_a[slot];
          r.vertex_b = recent_b[slot];
        end else begin
          r.vertex_a = recent_b[slot];
          r.vertex_b = recent_a[slot];
        end
      end
    end else if (k < 94) begin
      r.req_type = REQ_COUNT;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // Check each result beat against the oldest prediction
  always @(posedge clk_i) begin
    gcc_res_t want;
    if (rst_ni && done_o) begin
      if (results_due.size() == 0) begin
        fails++;
        if (fails <= 20)
          $display("%0t: unexpected result st=%0d cc=%0d ec=%0d", $time,
                   res_o.status, res_o.component_count, res_o.edge_count);
      end else begin
        want = results_due.pop_front();
        if (res_o.status !== want.status ||
            res_o.component_count !== want.component_count ||
            res_o.edge_count !== want.edge_count) begin
          fails++;
          if (fails <= 20)
            $display("%0t: mismatch exp st=%0d cc=%0d ec=%0d got st=%0d cc=%0d ec=%0d",
                     $time, want.status, want.component_count, want.edge_count,
                     res_o.status, res_o.component_count, res_o.edge_count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [CntW-1:0] phase_vcnt [NumPhases];
    gcc_res_t        none;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    start       <= 1'b0;
    req_i       <= '0;
    none = '0;
    for (int v = 0; v < NumVert; v++) adj_rows[v] = '0;
    edges_now = '0;
    comps_now = '0;
    vcnt_now  = 7'd64;
    recent_wr = 0;
    for (int i = 0; i < 16; i++) begin
      recent_a[i] = '0;
      recent_b[i] = '0;
    end
    fails = 0; cycles = 0;
    n_items = 0; n_counts = 0; n_flagged = 0; n_cfg = 0;
    idle_en = 1'b1;

    // After reset: 64 isolated vertices; field extremes, duplicates, self-loops
    directed_plan.push_back(plan(64, REQ_COUNT,   0,  0, 1, 0, 64, 0));
    directed_plan.push_back(plan(64, REQ_INSERT,  0, 63, 1, 0, 64, 1));
    directed_plan.push_back(plan(64, REQ_INSERT, 63,  0, 1, 0, 64, 1));
    directed_plan.push_back(plan(64, REQ_INSERT,  5,  5, 1, 0, 64, 2));
    directed_plan.push_back(plan(64, REQ_COUNT,   0,  0, 1, 0, 63, 2));
    directed_plan.push_back(plan(64, REQ_REMOVE, 63,  0, 1, 0, 63, 1));
    directed_plan.push_back(plan(64, REQ_REMOVE,  0, 63, 1, 0, 63, 1));
    directed_plan.push_back(plan(64, REQ_UNUSED, 63, 63, 1, 0, 63, 1));
    directed_plan.push_back(plan(64, REQ_COUNT,  63, 63, 1, 0, 64, 1));
    directed_plan.push_back(plan(64, REQ_INSERT, 63, 63, 1, 0, 64, 2));
    directed_plan.push_back(plan(64, REQ_REMOVE,  5,  5, 1, 0, 64, 1));
    directed_plan.push_back(plan(64, REQ_INSERT,  1,  2, 0, 0, 0, 0));
    directed_plan.push_back(plan(64, REQ_INSERT,  2,  3, 0, 0, 0, 0));
    directed_plan.push_back(plan(64, REQ_INSERT,  3,  1, 0, 0, 0, 0));
    directed_plan.push_back(plan(64, REQ_COUNT,   0,  0, 0, 0, 0, 0));
    // Small vertex count: out-of-range endpoints are flagged
    directed_plan.push_back(plan(4,  REQ_INSERT,  3,  4, 0, 0, 0, 0));
    directed_plan.push_back(plan(4,  REQ_INSERT,  4,  3, 0, 0, 0, 0));
    directed_plan.push_back(plan(4,  REQ_REMOVE,  0,  4, 0, 0, 0, 0));
    directed_plan.push_back(plan(4,  REQ_COUNT,   0,  0, 0, 0, 0, 0));
    directed_plan.push_back(plan(4,  REQ_INSERT,  0,  3, 0, 0, 0, 0));
    // Zero vertex count flags every edge request and counts nothing
    directed_plan.push_back(plan(0,  REQ_INSERT,  0,  0, 0, 0, 0, 0));
    directed_plan.push_back(plan(0,  REQ_REMOVE,  0,  0, 0, 0, 0, 0));
    directed_plan.push_back(plan(0,  REQ_COUNT,   0,  0, 0, 0, 0, 0));
    // Register above the field reach clamps to 64
    directed_plan.push_back(plan(127, REQ_COUNT,  0,  0, 0, 0, 0, 0));
    directed_plan.push_back(plan(127, REQ_INSERT, 63, 62, 0, 0, 0, 0));
    directed_plan.push_back(plan(1,  REQ_INSERT,  0,  0, 0, 0, 0, 0));
    directed_plan.push_back(plan(1,  REQ_INSERT,  0,  1, 0, 0, 0, 0));
    directed_plan.push_back(plan(1,  REQ_COUNT,   0,  0, 0, 0, 0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].vcnt != vcnt_now) set_vertex_count(directed_plan[i].vcnt);
      issue(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].res);
      pause_sender();
    end

    phase_vcnt = '{7'd64, 7'd1, 7'd12, 7'd127, 7'd2, 7'd64, 7'd0, 7'd40, 7'd7, 7'd64};
    phase_vcnt[7] = CntW'($urandom_range(63, 3));
    for (int p = 0; p < NumPhases; p++) begin
      set_vertex_count(phase_vcnt[p]);
      idle_en = (p != 5);
      for (int i = 0; i < RandPerPhase; i++) begin
        issue(random_req(), 1'b0, none);
        pause_sender();
      end
    end

    start <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
    repeat (400) @(posedge clk_i);

    $display("Covered %0d requests (%0d component counts, %0d flagged) over %0d register writes",
             n_items, n_counts, n_flagged, n_cfg);
    $display("Vertex counts swept from 0 to 127, with %0d edges left stored", edges_now);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
